@@ src/hsfcm_pkg.sv @@
// Shared types, constants and helper functions for the sensor frame check monitor.
`timescale 1ns / 1ps

package hsfcm_pkg;

	// APB register map
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam logic [1:0] REG_TICK_DIVIDE     = 2'd0;
	localparam logic [1:0] REG_FAULT_LIMIT     = 2'd1;
	localparam logic [1:0] REG_ST_FAULT_LIMIT  = 2'd2;
	localparam logic [1:0] REG_SELF_TEST       = 2'd3;

	localparam logic [7:0] TICK_DIVIDE_RST     = 8'd3;
	localparam logic [7:0] FAULT_LIMIT_RST     = 8'd10;
	localparam logic [7:0] ST_FAULT_LIMIT_RST  = 8'd3;

	// Request queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	localparam logic [2:0] FRAME_BYTES = 3'd6;
	localparam logic [7:0] CRC_POLY    = 8'h31;
	localparam logic [7:0] CRC_INIT    = 8'hFF;
	localparam logic [7:0] MISS_MAX    = 8'hFF;

	typedef enum logic [1:0] {
		REQ_TICK = 2'd0,
		REQ_ACK  = 2'd1,
		REQ_BYTE = 2'd2,
		REQ_NONE = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_CMD  = 2'd1,
		ACT_READ = 2'd2
	} action_t;

	typedef struct packed {
		req_kind_t  kind;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		logic [7:0] tick_divide;
		logic [7:0] fault_limit;
		logic [7:0] self_test_fault_limit;
		logic       self_test;
	} cfg_t;

	// CRC-8, MSB first, one byte
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	// raw*100/65535 truncated: quotient estimate from the top bits, then one correction
	function automatic logic [6:0] hum_percent(input logic [15:0] raw);
		logic [22:0] prod;
		logic [6:0]  q0;
		logic [16:0] rem;
		prod = {7'd0, raw} * 23'd100;
		q0   = prod[22:16];
		rem  = {1'b0, prod[15:0]} + {10'd0, q0};
		return (rem >= 17'h0FFFF) ? q0 + 7'd1 : q0;
	endfunction

endpackage

@@ src/hsfcm_regs.sv @@
// APB configuration registers.
`timescale 1ns / 1ps

module hsfcm_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hsfcm_pkg::ADDR_W-1:0]  paddr,
	input  logic [hsfcm_pkg::DATA_W-1:0]  pwdata,
	output logic [hsfcm_pkg::DATA_W-1:0]  prdata,
	output logic                          pready,
	output hsfcm_pkg::cfg_t               cfg
);

	hsfcm_pkg::cfg_t cfg_q;
	logic [1:0]      reg_sel;
	logic            wr_en;

	assign reg_sel = paddr[hsfcm_pkg::ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_divide           <= hsfcm_pkg::TICK_DIVIDE_RST;
			cfg_q.fault_limit           <= hsfcm_pkg::FAULT_LIMIT_RST;
			cfg_q.self_test_fault_limit <= hsfcm_pkg::ST_FAULT_LIMIT_RST;
			cfg_q.self_test             <= 1'b0;
		end else if (wr_en) begin
			case (reg_sel)
				hsfcm_pkg::REG_TICK_DIVIDE:    cfg_q.tick_divide <= pwdata[7:0];
				hsfcm_pkg::REG_FAULT_LIMIT:    cfg_q.fault_limit <= pwdata[7:0];
				hsfcm_pkg::REG_ST_FAULT_LIMIT: cfg_q.self_test_fault_limit <= pwdata[7:0];
				hsfcm_pkg::REG_SELF_TEST:      cfg_q.self_test <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			hsfcm_pkg::REG_TICK_DIVIDE:    prdata = {24'd0, cfg_q.tick_divide};
			hsfcm_pkg::REG_FAULT_LIMIT:    prdata = {24'd0, cfg_q.fault_limit};
			hsfcm_pkg::REG_ST_FAULT_LIMIT: prdata = {24'd0, cfg_q.self_test_fault_limit};
			hsfcm_pkg::REG_SELF_TEST:      prdata = {31'd0, cfg_q.self_test};
			default:                       prdata = '0;
		endcase
	end

endmodule

@@ src/hsfcm_front.sv @@
// Front end: accepts requests, classifies them and queues them for the back end.
`timescale 1ns / 1ps

module hsfcm_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           req_type,
	input  logic [7:0]           rx_byte,
	output logic                 q_valid,
	output hsfcm_pkg::item_t     q_item,
	input  logic                 q_pop
);

	hsfcm_pkg::item_t                 mem_q [hsfcm_pkg::QUEUE_DEPTH];
	logic [hsfcm_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [hsfcm_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [hsfcm_pkg::QCNT_W-1:0]     count_q;
	hsfcm_pkg::item_t                 cls;
	logic                             push;
	logic                             pop;

	always_comb begin
		case (req_type)
			hsfcm_pkg::REQ_TICK: cls.kind = hsfcm_pkg::REQ_TICK;
			hsfcm_pkg::REQ_ACK:  cls.kind = hsfcm_pkg::REQ_ACK;
			hsfcm_pkg::REQ_BYTE: cls.kind = hsfcm_pkg::REQ_BYTE;
			default:             cls.kind = hsfcm_pkg::REQ_NONE;
		endcase
		cls.data = (cls.kind == hsfcm_pkg::REQ_BYTE) ? rx_byte : 8'd0;
	end

	assign in_ready = (count_q != hsfcm_pkg::QCNT_W'(hsfcm_pkg::QUEUE_DEPTH));
	assign q_valid  = (count_q != '0);
	assign q_item   = mem_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + hsfcm_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - hsfcm_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ src/hsfcm_back.sv @@
// Back end: polling prescaler, fault tracking, frame CRC check and result register.
`timescale 1ns / 1ps

module hsfcm_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hsfcm_pkg::cfg_t      cfg,
	input  logic                 q_valid,
	input  hsfcm_pkg::item_t     q_item,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           action,
	output logic                 fault,
	output logic [15:0]          temperature_raw,
	output logic [6:0]           humidity_percent,
	output logic                 temperature_updated,
	output logic                 humidity_updated
);

	logic [7:0]  tick_count_q, tick_count_d;
	logic [7:0]  miss_count_q, miss_count_d;
	logic        command_phase_q, command_phase_d;
	logic        fault_flag_q, fault_flag_d;
	logic [2:0]  byte_index_q, byte_index_d;
	logic [7:0]  running_crc_q, running_crc_d;
	logic [7:0]  word_high_q;
	logic [7:0]  word_low_q;
	logic [6:0]  hum_cand_q;
	logic [15:0] temp_store_q, temp_store_d;
	logic [6:0]  hum_store_q, hum_store_d;

	logic        take;
	logic [7:0]  tick_inc;
	logic [7:0]  miss_inc;
	logic        wr_high, wr_low;
	hsfcm_pkg::action_t act_d;
	logic        t_upd_d, h_upd_d;

	logic        out_valid_q;
	logic [1:0]  action_q;
	logic        fault_q;
	logic [15:0] temp_out_q;
	logic [6:0]  hum_out_q;
	logic        t_upd_q, h_upd_q;

	assign take  = q_valid && (!out_valid_q || out_ready);
	assign q_pop = take;

	assign tick_inc = tick_count_q + 8'd1;

	always_comb begin
		tick_count_d    = tick_count_q;
		miss_count_d    = miss_count_q;
		command_phase_d = command_phase_q;
		fault_flag_d    = fault_flag_q;
		byte_index_d    = byte_index_q;
		running_crc_d   = running_crc_q;
		temp_store_d    = temp_store_q;
		hum_store_d     = hum_store_q;
		miss_inc        = (miss_count_q != hsfcm_pkg::MISS_MAX) ? miss_count_q + 8'd1 : miss_count_q;
		wr_high         = 1'b0;
		wr_low          = 1'b0;
		act_d           = hsfcm_pkg::ACT_NONE;
		t_upd_d         = 1'b0;
		h_upd_d         = 1'b0;
		case (q_item.kind)
			hsfcm_pkg::REQ_TICK: begin
				tick_count_d = tick_inc;
				if (tick_inc >= cfg.tick_divide) begin
					tick_count_d = 8'd0;
					miss_count_d = miss_inc;
					fault_flag_d = (miss_inc > cfg.fault_limit) ||
					               (cfg.self_test && (miss_inc > cfg.self_test_fault_limit));
					command_phase_d = !command_phase_q;
					if (command_phase_q) begin
						act_d = hsfcm_pkg::ACT_CMD;
					end else begin
						act_d         = hsfcm_pkg::ACT_READ;
						byte_index_d  = 3'd0;
						running_crc_d = hsfcm_pkg::CRC_INIT;
					end
				end
			end
			hsfcm_pkg::REQ_ACK: begin
				miss_count_d = 8'd0;
			end
			hsfcm_pkg::REQ_BYTE: begin
				if (byte_index_q < hsfcm_pkg::FRAME_BYTES) begin
					byte_index_d = byte_index_q + 3'd1;
					// bytes 0/3 high word, 1/4 low word, 2/5 CRC
					case (byte_index_q)
						3'd0, 3'd3: begin
							wr_high       = 1'b1;
							running_crc_d = hsfcm_pkg::crc8_byte(running_crc_q, q_item.data);
						end
						3'd1, 3'd4: begin
							wr_low        = 1'b1;
							running_crc_d = hsfcm_pkg::crc8_byte(running_crc_q, q_item.data);
						end
						default: begin
							running_crc_d = hsfcm_pkg::CRC_INIT;
							if (running_crc_q == q_item.data) begin
								if (byte_index_q == 3'd2) begin
									temp_store_d = {word_high_q, word_low_q};
									t_upd_d      = 1'b1;
								end else begin
									hum_store_d = hum_cand_q;
									h_upd_d     = 1'b1;
								end
							end
						end
					endcase
				end
			end
			default: ;
		endcase
	end

	// word capture; the humidity percentage is worked out as the low byte lands
	always_ff @(posedge clk) begin
		if (take && wr_high) begin
			word_high_q <= q_item.data;
		end
		if (take && wr_low) begin
			word_low_q <= q_item.data;
			hum_cand_q <= hsfcm_pkg::hum_percent({word_high_q, q_item.data});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q    <= 8'd0;
			miss_count_q    <= 8'd0;
			command_phase_q <= 1'b1;
			fault_flag_q    <= 1'b0;
			byte_index_q    <= hsfcm_pkg::FRAME_BYTES;
			running_crc_q   <= hsfcm_pkg::CRC_INIT;
			temp_store_q    <= 16'd0;
			hum_store_q     <= 7'd0;
			out_valid_q     <= 1'b0;
		end else begin
			if (take) begin
				tick_count_q    <= tick_count_d;
				miss_count_q    <= miss_count_d;
				command_phase_q <= command_phase_d;
				fault_flag_q    <= fault_flag_d;
				byte_index_q    <= byte_index_d;
				running_crc_q   <= running_crc_d;
				temp_store_q    <= temp_store_d;
				hum_store_q     <= hum_store_d;
				out_valid_q     <= 1'b1;
			end else if (out_ready) begin
				out_valid_q     <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			action_q   <= act_d;
			fault_q    <= fault_flag_d;
			temp_out_q <= temp_store_d;
			hum_out_q  <= hum_store_d;
			t_upd_q    <= t_upd_d;
			h_upd_q    <= h_upd_d;
		end
	end

	assign out_valid           = out_valid_q;
	assign action              = action_q;
	assign fault               = fault_q;
	assign temperature_raw     = temp_out_q;
	assign humidity_percent    = hum_out_q;
	assign temperature_updated = t_upd_q;
	assign humidity_updated    = h_upd_q;

endmodule

@@ src/humidity_sensor_frame_check_monitor_unit.sv @@
// Top level of the sensor frame check monitor.
`timescale 1ns / 1ps

// Every request gives exactly one result. Requests are base ticks, transfer
// acknowledges and received frame bytes; each tick_divide-th tick is a polling
// step that bumps the miss counter, re-evaluates the fault flag and alternates
// between a measurement command and a frame read. Frame words are CRC-8 checked
// (poly 0x31, init 0xFF) before the stored temperature or humidity changes.
// One request per cycle sustained while out_ready stays high; an accepted
// request is written into the front queue, then taken by the back end into
// the result register when the output is free. A two-entry queue lets the
// input keep taking requests while a result waits. Configuration is written
// over APB; the user must do so only while idle, the block does not enforce it.

module humidity_sensor_frame_check_monitor_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hsfcm_pkg::ADDR_W-1:0]  paddr,
	input  logic [hsfcm_pkg::DATA_W-1:0]  pwdata,
	output logic [hsfcm_pkg::DATA_W-1:0]  prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    req_type,
	input  logic [7:0]                    rx_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    action,
	output logic                          fault,
	output logic [15:0]                   temperature_raw,
	output logic [6:0]                    humidity_percent,
	output logic                          temperature_updated,
	output logic                          humidity_updated
);

	hsfcm_pkg::cfg_t  cfg;
	logic             q_valid;
	hsfcm_pkg::item_t q_item;
	logic             q_pop;

	hsfcm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	hsfcm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.rx_byte  (rx_byte),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	hsfcm_back u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg                 (cfg),
		.q_valid             (q_valid),
		.q_item              (q_item),
		.q_pop               (q_pop),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.action              (action),
		.fault               (fault),
		.temperature_raw     (temperature_raw),
		.humidity_percent    (humidity_percent),
		.temperature_updated (temperature_updated),
		.humidity_updated    (humidity_updated)
	);

	// a request cannot both start a bus action and store a value
	a_act_no_update: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action != hsfcm_pkg::ACT_NONE) |-> !temperature_updated && !humidity_updated)
		else $error("action and value update on the same request");

	a_one_update: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(temperature_updated && humidity_updated))
		else $error("both stores updated by one request");

	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> humidity_percent <= 7'd100)
		else $error("humidity percentage out of range");

	// back end only pops what the queue holds
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

endmodule
